// File: rtl/tlc_pkg.sv
// shared types and constants of the traffic light controller
`timescale 1ns / 1ps

package tlc_pkg;

	localparam int unsigned DebounceW = 8;
	localparam int unsigned TimeW     = 16;
	localparam int unsigned CfgIdxW   = 3;

	typedef enum logic [2:0] {
		PH_RED_MIN  = 3'd0,
		PH_RED_REST = 3'd1,
		PH_GREEN    = 3'd2,
		PH_B1_OFF   = 3'd3,
		PH_B1_ON    = 3'd4,
		PH_B2_OFF   = 3'd5,
		PH_B2_ON    = 3'd6,
		PH_YELLOW   = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		LAMP_NONE   = 2'd0,
		LAMP_RED    = 2'd1,
		LAMP_GREEN  = 2'd2,
		LAMP_YELLOW = 2'd3
	} lamp_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEBOUNCE = 3'd0,
		REG_RED_MIN  = 3'd1,
		REG_RED_REST = 3'd2,
		REG_GREEN    = 3'd3,
		REG_BLINK    = 3'd4,
		REG_YELLOW   = 3'd5
	} cfg_reg_t;

	localparam logic [DebounceW-1:0] DebounceReset = 8'd5;
	localparam logic [TimeW-1:0]     RedMinReset   = 16'd2000;
	localparam logic [TimeW-1:0]     RedRestReset  = 16'd6000;
	localparam logic [TimeW-1:0]     GreenReset    = 16'd2000;
	localparam logic [TimeW-1:0]     BlinkReset    = 16'd100;
	localparam logic [TimeW-1:0]     YellowReset   = 16'd1000;

	typedef struct packed {
		logic [TimeW-1:0] red_min;
		logic [TimeW-1:0] red_rest;
		logic [TimeW-1:0] green;
		logic [TimeW-1:0] blink;
		logic [TimeW-1:0] yellow;
	} timing_t;

	typedef struct packed {
		logic   request;
		phase_t phase;
		lamp_t  lamp;
	} result_t;

endpackage

// File: rtl/tlc_debounce.sv
// button debouncer making a single press event per held press
`timescale 1ns / 1ps

module tlc_debounce
	import tlc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 level,
	input  logic [DebounceW-1:0] debounce_ms,
	output logic                 press
);

	logic [DebounceW-1:0] hold_count_q;
	logic                 holding_q;
	logic [DebounceW-1:0] hold_next;
	logic [DebounceW-1:0] held_time;
	logic                 past_limit;

	// held time is the saturated count minus one, so it tops out one below max
	always_comb begin
		hold_next  = (hold_count_q == {DebounceW{1'b1}}) ? hold_count_q
			: hold_count_q + 1'b1;
		held_time  = (hold_count_q == {DebounceW{1'b1}}) ? hold_count_q - 1'b1
			: hold_count_q;
		past_limit = level && (held_time > debounce_ms);
		press      = past_limit && !holding_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count_q <= '0;
			holding_q    <= 1'b0;
		end else if (en) begin
			if (level) begin
				hold_count_q <= hold_next;
				if (past_limit)
					holding_q <= 1'b1;
			end else begin
				hold_count_q <= '0;
				holding_q    <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/tlc_sequencer.sv
// eight-phase light sequencer with crossing request latch
`timescale 1ns / 1ps

module tlc_sequencer
	import tlc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    press,
	input  timing_t timing,
	output result_t result
);

	phase_t           phase_q, phase_d;
	lamp_t            lamp_q, lamp_d;
	logic             request_q, request_d;
	logic [TimeW-1:0] elapsed_q, elapsed_d;
	logic             request_set;
	logic             done;

	// elapsed + 1 > duration is the same as elapsed >= duration with saturation
	always_comb begin
		request_set = request_q || (press && (phase_q != PH_GREEN));
		request_d   = request_set;
		phase_d     = phase_q;
		lamp_d      = lamp_q;
		done        = 1'b0;
		elapsed_d   = (elapsed_q == {TimeW{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
		case (phase_q)
			PH_RED_MIN: begin
				done    = elapsed_q >= timing.red_min;
				phase_d = done ? PH_RED_REST : phase_q;
			end
			PH_RED_REST: begin
				done = (elapsed_q >= timing.red_rest) || request_set;
				if (done) begin
					phase_d   = PH_GREEN;
					lamp_d    = LAMP_GREEN;
					request_d = 1'b0;
				end
			end
			PH_GREEN: begin
				done = elapsed_q >= timing.green;
				if (done) begin
					phase_d = PH_B1_OFF;
					lamp_d  = LAMP_NONE;
				end
			end
			PH_B1_OFF: begin
				done = elapsed_q >= timing.blink;
				if (done) begin
					phase_d = PH_B1_ON;
					lamp_d  = LAMP_GREEN;
				end
			end
			PH_B1_ON: begin
				done = elapsed_q >= timing.blink;
				if (done) begin
					phase_d = PH_B2_OFF;
					lamp_d  = LAMP_NONE;
				end
			end
			PH_B2_OFF: begin
				done = elapsed_q >= timing.blink;
				if (done) begin
					phase_d = PH_B2_ON;
					lamp_d  = LAMP_GREEN;
				end
			end
			PH_B2_ON: begin
				done = elapsed_q >= timing.blink;
				if (done) begin
					phase_d = PH_YELLOW;
					lamp_d  = LAMP_YELLOW;
				end
			end
			default: begin
				done = elapsed_q >= timing.yellow;
				if (done) begin
					phase_d = PH_RED_MIN;
					lamp_d  = LAMP_RED;
				end
			end
		endcase
		if (done)
			elapsed_d = '0;
		result.lamp    = lamp_d;
		result.phase   = phase_d;
		result.request = request_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_YELLOW;
			lamp_q    <= LAMP_NONE;
			request_q <= 1'b0;
			elapsed_q <= '0;
		end else if (en) begin
			phase_q   <= phase_d;
			lamp_q    <= lamp_d;
			request_q <= request_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

// File: rtl/traffic_light_with_crossing_request.sv
// Traffic light controller with a pedestrian crossing button, top level.
// Each input item is one millisecond tick carrying the sampled button level;
// each tick gives exactly one result item with the lamp, the phase and the
// pending crossing request as they stand after that tick. The block takes
// one item per clock cycle while results are taken: the item is held in an
// input register, goes through the debouncer and the phase sequencer in short
// logic (counter increments and compares) and lands in the result register.
// While a result waits, the input register still takes one more item, and
// after that the input stalls until the result is taken. Durations are to be
// written on the configuration channel while idle; the block does not enforce
// it. Index 0 debounce time (8 bit), 1 red minimum, 2 red remainder, 3 green,
// 4 blink half, 5 yellow (16 bit each, from cfg_data); other indexes are
// dropped. The lamp reads none after reset until the yellow phase first ends.
`timescale 1ns / 1ps

module traffic_light_with_crossing_request
	import tlc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input ticks
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [0] button_level, rest zero padding
	// result items
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [1:0] lamp, [4:2] phase, [5] request_pending
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [TimeW-1:0]   cfg_data
);

	logic                 valid_s1;
	logic                 button_s1;
	logic                 advance;
	logic                 press;
	result_t              result;
	logic [DebounceW-1:0] debounce_q;
	timing_t              timing_q;
	logic                 out_valid_q;
	result_t              out_q;

	// item moves from the input register into the result register
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			button_s1 <= s_tdata[0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q        <= DebounceReset;
			timing_q.red_min  <= RedMinReset;
			timing_q.red_rest <= RedRestReset;
			timing_q.green    <= GreenReset;
			timing_q.blink    <= BlinkReset;
			timing_q.yellow   <= YellowReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q        <= cfg_data[DebounceW-1:0];
				REG_RED_MIN:  timing_q.red_min  <= cfg_data;
				REG_RED_REST: timing_q.red_rest <= cfg_data;
				REG_GREEN:    timing_q.green    <= cfg_data;
				REG_BLINK:    timing_q.blink    <= cfg_data;
				REG_YELLOW:   timing_q.yellow   <= cfg_data;
				default: ;
			endcase
		end
	end

	// debouncer state steps once per item
	tlc_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.level       (button_s1),
		.debounce_ms (debounce_q),
		.press       (press)
	);

	// sequencer gives the post-tick lamp, phase and request
	tlc_sequencer u_sequencer (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.press  (press),
		.timing (timing_q),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.request, out_q.phase, out_q.lamp};

endmodule

// File: rtl/tlc_checker.sv
// port-level checks of the traffic light controller, bound to the top level
`timescale 1ns / 1ps

module tlc_checker
	import tlc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// a stalled result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// steady green and blink on phases light green
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[4:2] == PH_GREEN || m_tdata[4:2] == PH_B1_ON
			|| m_tdata[4:2] == PH_B2_ON) |-> m_tdata[1:0] == LAMP_GREEN)
		else $error("green phase without green lamp");

	// blink off phases are dark
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[4:2] == PH_B1_OFF || m_tdata[4:2] == PH_B2_OFF)
		|-> m_tdata[1:0] == LAMP_NONE)
		else $error("blink off phase with lamp lit");

	// both red phases show red
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[4:2] == PH_RED_MIN || m_tdata[4:2] == PH_RED_REST)
		|-> m_tdata[1:0] == LAMP_RED)
		else $error("red phase without red lamp");

	// request is served on entry to green and not latched during it
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4:2] == PH_GREEN |-> !m_tdata[5])
		else $error("request pending during green");

endmodule

bind traffic_light_with_crossing_request tlc_checker u_tlc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
